>>> sv/srs_pkg.sv
`default_nettype none

package srs_pkg;

  localparam int unsigned SeqW   = 64;
  localparam int unsigned CountW = 5;
  localparam int unsigned CountMax = 31;

  typedef enum logic {
    OpAdd   = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef struct packed {
    op_e              operation;
    logic [SeqW-1:0]  seq_value;
  } req_t;

  typedef struct packed {
    logic               was_present;
    logic               dropped;
    logic [CountW-1:0]  range_count;
  } rsp_t;

endpackage

`default_nettype wire

>>> sv/sequence_range_set.sv
`default_nettype none

// Channel   | Ports                            | Direction | Handshake
// ----------+----------------------------------+-----------+-----------------------------
// request   | start, busy, req_i               | in        | taken when start && !busy
// result    | rsp_valid_o, rsp_o               | out       | one-cycle strobe, no stall
//
// One request per cycle; busy is never raised. A request lands in the input
// register at the edge that takes it, is resolved against all ranges in the
// following cycle (parallel compare of every entry, one range update), and its
// result is on the outputs for the cycle after that. The next request sees the
// updated table, so back-to-back adds are handled in order. Reset clears all
// entries, valid bits and the range count at once; no clearing pass. The
// receiver cannot stall, so nothing is held.

module sequence_range_set #(
  parameter int unsigned NUM_RANGES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire srs_pkg::req_t req_i,
  output logic               rsp_valid_o,
  output srs_pkg::rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(NUM_RANGES + 1);
  localparam int unsigned ExtW = (CntW > srs_pkg::CountW) ? CntW : srs_pkg::CountW;

  // input register
  srs_pkg::req_t req_q;
  logic          pend_q;

  // range table
  logic [srs_pkg::SeqW-1:0] start_q [NUM_RANGES];
  logic [srs_pkg::SeqW-1:0] start_d [NUM_RANGES];
  logic [srs_pkg::SeqW-1:0] end_q   [NUM_RANGES];
  logic [srs_pkg::SeqW-1:0] end_d   [NUM_RANGES];
  logic [NUM_RANGES-1:0]    valid_q, valid_d;
  logic [CntW-1:0]          count_q, count_d;

  // result register
  srs_pkg::rsp_t rsp_q, rsp_d;
  logic          rsp_valid_q;

  logic [srs_pkg::SeqW-1:0] v, v_dec, v_inc, hi_end;
  logic [NUM_RANGES-1:0]    cover_hit, lo_hit, hi_hit, free_oh;
  logic                     present, lo_any, hi_any, has_free, is_add;
  logic                     bridge, extend, claim, drop;
  logic [ExtW-1:0]          count_ext;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      req_q <= req_i;
    end
  end

  assign v     = req_q.seq_value;
  assign v_dec = v - srs_pkg::SeqW'(1);
  assign v_inc = v + srs_pkg::SeqW'(1);

  // per-entry compares, all side by side
  always_comb begin
    cover_hit = '0;
    lo_hit    = '0;
    hi_hit    = '0;
    hi_end    = '0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      cover_hit[i] = valid_q[i] && (start_q[i] <= v) && (v <= end_q[i]);
      lo_hit[i]    = valid_q[i] && (v != '0) && (end_q[i] == v_dec);
      hi_hit[i]    = valid_q[i] && (v != '1) && (start_q[i] == v_inc);
      if (hi_hit[i]) begin
        hi_end = hi_end | end_q[i];
      end
    end
  end

  // lowest free entry: lowest zero of the valid vector
  assign free_oh  = ~valid_q & (valid_q + NUM_RANGES'(1));
  assign has_free = ~&valid_q;

  assign present = |cover_hit;
  assign lo_any  = |lo_hit;
  assign hi_any  = |hi_hit;
  assign is_add  = pend_q && (req_q.operation == srs_pkg::OpAdd) && !present;
  assign bridge  = is_add && lo_any && hi_any;
  assign extend  = is_add && (lo_any ^ hi_any);
  assign claim   = is_add && !lo_any && !hi_any && has_free;
  assign drop    = is_add && !lo_any && !hi_any && !has_free;

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < NUM_RANGES; i++) begin
      start_d[i] = start_q[i];
      end_d[i]   = end_q[i];
      if (bridge) begin
        if (lo_hit[i]) begin
          end_d[i] = hi_end;
        end
        if (hi_hit[i]) begin
          valid_d[i] = 1'b0;
          start_d[i] = '0;
          end_d[i]   = '0;
        end
      end else if (extend) begin
        if (lo_hit[i]) begin
          end_d[i] = v;
        end
        if (hi_hit[i]) begin
          start_d[i] = v;
        end
      end else if (claim && free_oh[i]) begin
        start_d[i] = v;
        end_d[i]   = v;
        valid_d[i] = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (bridge) begin
      count_d = count_q - CntW'(1);
    end else if (claim) begin
      count_d = count_q + CntW'(1);
    end else begin
      count_d = count_q;
    end
  end

  // saturate the reported count at 31
  assign count_ext = ExtW'(count_d);

  always_comb begin
    rsp_d.was_present = present;
    rsp_d.dropped     = drop;
    if (count_ext > ExtW'(srs_pkg::CountMax)) begin
      rsp_d.range_count = srs_pkg::CountW'(srs_pkg::CountMax);
    end else begin
      rsp_d.range_count = count_ext[srs_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < NUM_RANGES; i++) begin
        start_q[i] <= '0;
        end_q[i]   <= '0;
      end
    end else begin
      valid_q     <= valid_d;
      count_q     <= count_d;
      rsp_valid_q <= pend_q;
      for (int i = 0; i < NUM_RANGES; i++) begin
        start_q[i] <= start_d[i];
        end_q[i]   <= end_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

// Testbench for sequence_range_set.
// A short directed table walks the set through empty, the two ends of the
// 64-bit space, merges from below and above, a bridge, a full table, a drop
// and a merge that still works on a full table. Three random phases follow.
// Their values are drawn mostly around the ranges already stored, so the ranges
// grow, bridge, free entries and fill up again. Every taken request is run
// through a local copy of the range table to get its expected result. The
// results arrive as one-cycle strobes and are checked in order.

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries = 16;
  localparam logic [srs_pkg::SeqW-1:0] SeqTop = '1;
  localparam int unsigned RandPerPhase = 620;

  // One row of the directed table. Rows with expect_set carry a result that
  // can be read off by hand. All other rows use the predictor.
  typedef struct {
    srs_pkg::req_t req;
    bit            expect_set;
    srs_pkg::rsp_t rsp;
  } stim_row_t;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  logic          busy;
  srs_pkg::req_t req    = '0;
  logic          rsp_valid;
  srs_pkg::rsp_t rsp;

  // Local copy of the range table. It is updated when a request is taken.
  logic [srs_pkg::SeqW-1:0] span_lo   [Entries];
  logic [srs_pkg::SeqW-1:0] span_hi   [Entries];
  bit                       span_used [Entries];

  srs_pkg::rsp_t pending_rsp [$];    // expected results, oldest first
  int   mismatch_cnt = 0;
  int   sender_idle_pct = 0;

  sequence_range_set #(
    .NUM_RANGES (Entries)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop. This is far above the slowest correct run, about 2k requests
  // with the long sender gaps.
  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Resolve one request against the local table and return its result.
  // An add that is not covered joins the range that ends just below the
  // value and/or the one that starts just above it. Failing that, it takes
  // the lowest free entry, or it is dropped. No join crosses the wrap from
  // the top value to zero.
  function automatic srs_pkg::rsp_t resolve_seq(srs_pkg::req_t r);
    srs_pkg::rsp_t res;
    logic [srs_pkg::SeqW-1:0] v;
    int below, above, vacant, n;
    bit hit;
    v = r.seq_value;
    hit = 1'b0;
    below = -1;
    above = -1;
    vacant = -1;
    n = 0;
    for (int i = 0; i < Entries; i++) begin
      if (span_used[i] && span_lo[i] <= v && v <= span_hi[i]) hit = 1'b1;
    end
    res = '0;
    res.was_present = hit;
    if (r.operation == srs_pkg::OpAdd && !hit) begin
      for (int i = 0; i < Entries; i++) begin
        if (!span_used[i]) begin
          if (vacant < 0) vacant = i;
        end else begin
          if (v != '0 && span_hi[i] == v - 1'b1) below = i;
          if (v != SeqTop && span_lo[i] == v + 1'b1) above = i;
        end
      end
      if (below >= 0 && above >= 0) begin
        // bridge: the lower entry absorbs the upper one, and the upper
        // entry is freed
        span_hi[below]   = span_hi[above];
        span_used[above] = 1'b0;
        span_lo[above]   = '0;
        span_hi[above]   = '0;
      end else if (below >= 0) begin
        span_hi[below] = v;
      end else if (above >= 0) begin
        span_lo[above] = v;
      end else if (vacant >= 0) begin
        span_lo[vacant]   = v;
        span_hi[vacant]   = v;
        span_used[vacant] = 1'b1;
      end else begin
        res.dropped = 1'b1;
      end
    end
    for (int i = 0; i < Entries; i++) begin
      if (span_used[i]) n++;
    end
    res.range_count = (n > srs_pkg::CountMax) ? srs_pkg::CountW'(srs_pkg::CountMax)
                                              : srs_pkg::CountW'(n);
    return res;
  endfunction

  function automatic stim_row_t row(srs_pkg::op_e op, logic [srs_pkg::SeqW-1:0] v,
                                    bit known = 1'b0,
                                    logic wp = 1'b0, logic dr = 1'b0,
                                    logic [srs_pkg::CountW-1:0] cnt = '0);
    stim_row_t s;
    s.req.operation    = op;
    s.req.seq_value    = v;
    s.expect_set       = known;
    s.rsp.was_present  = wp;
    s.rsp.dropped      = dr;
    s.rsp.range_count  = cnt;
    return s;
  endfunction

  // Random request. Values are mostly taken around a stored range: just
  // past either end (extend, maybe bridge), inside it (covered), or a few
  // steps away (a new range that a later add can bridge to). A small share
  // is the 64-bit corners or fully random values, and the random ones are
  // mostly queries, so stray values do not take over the table.
  function automatic srs_pkg::req_t next_random_req();
    srs_pkg::req_t r;
    int used_idx [$];
    int sel, k;
    logic [srs_pkg::SeqW-1:0] v;
    for (int i = 0; i < Entries; i++) begin
      if (span_used[i]) used_idx = {used_idx, i};
    end
    r.operation = ($urandom_range(99) < 30) ? srs_pkg::OpQuery : srs_pkg::OpAdd;
    sel = $urandom_range(99);
    if (used_idx.size() == 0 || sel < 10) begin
      v = {$urandom, $urandom};
      if ($urandom_range(9) < 8) r.operation = srs_pkg::OpQuery;
    end else if (sel < 18) begin
      case ($urandom_range(3))
        0:       v = '0;
        1:       v = srs_pkg::SeqW'(1);
        2:       v = SeqTop - 1'b1;
        default: v = SeqTop;
      endcase
    end else begin
      k = used_idx[$urandom_range(used_idx.size() - 1)];
      if (sel < 50) begin
        v = $urandom_range(1) ? span_hi[k] + 1'b1 : span_lo[k] - 1'b1;
      end else if (sel < 65) begin
        v = span_lo[k] + srs_pkg::SeqW'($urandom_range(3));
        if (v > span_hi[k] || v < span_lo[k]) v = span_hi[k];
      end else begin
        v = $urandom_range(1) ? span_hi[k] + srs_pkg::SeqW'($urandom_range(5, 2))
                              : span_lo[k] - srs_pkg::SeqW'($urandom_range(5, 2));
      end
    end
    r.seq_value = v;
    return r;
  endfunction

  // Called at a falling edge. The task may idle first, then presents the
  // request and waits for it to be taken. The expectation is queued at that
  // rising edge, and the task returns at the next falling edge.
  task automatic send_req(srs_pkg::req_t r, bit known = 1'b0,
                          srs_pkg::rsp_t known_rsp = '0);
    int gap;
    srs_pkg::rsp_t predicted;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = resolve_seq(r);
    pending_rsp = {pending_rsp, (known ? known_rsp : predicted)};
    @(negedge clk_i);
  endtask

  // Hold requests off until every result is back.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_rsp.size() != 0);
  endtask

  task automatic note_mismatch(string what, int expv, int gotv);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, expv, gotv);
  endtask

  // Results are one-cycle strobes. Each one is checked at the edge that
  // takes it, against the oldest expectation.
  always @(posedge clk_i) begin
    srs_pkg::rsp_t want;
    if (rst_ni && rsp_valid === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        note_mismatch("unexpected result, count", 0, int'(rsp.range_count));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.was_present !== want.was_present)
          note_mismatch("was_present", int'(want.was_present), int'(rsp.was_present));
        if (rsp.dropped !== want.dropped)
          note_mismatch("dropped", int'(want.dropped), int'(rsp.dropped));
        if (rsp.range_count !== want.range_count)
          note_mismatch("range_count", int'(want.range_count), int'(rsp.range_count));
      end
    end
  end

  initial begin
    stim_row_t dir_tbl [$];
    int waited;

    for (int i = 0; i < Entries; i++) begin
      span_lo[i]   = '0;
      span_hi[i]   = '0;
      span_used[i] = 1'b0;
    end

    // Empty set, the two ends with no join across the wrap, joins from
    // below and from above, a bridge, a covered add, then filling to a full
    // table. The add past full is dropped, and a join on a full table still
    // goes through.
    dir_tbl = '{
      row(srs_pkg::OpQuery, '0,            1'b1, 1'b0, 1'b0, 5'd0),
      row(srs_pkg::OpAdd,   '0,            1'b1, 1'b0, 1'b0, 5'd1),
      row(srs_pkg::OpAdd,   SeqTop,        1'b1, 1'b0, 1'b0, 5'd2),
      row(srs_pkg::OpAdd,   SeqTop - 1'b1, 1'b1, 1'b0, 1'b0, 5'd2),
      row(srs_pkg::OpAdd,   64'd1,         1'b1, 1'b0, 1'b0, 5'd2),
      row(srs_pkg::OpAdd,   64'd3,         1'b1, 1'b0, 1'b0, 5'd3),
      row(srs_pkg::OpAdd,   64'd2,         1'b1, 1'b0, 1'b0, 5'd2),
      row(srs_pkg::OpAdd,   '0,            1'b1, 1'b1, 1'b0, 5'd2),
      row(srs_pkg::OpAdd, 64'd10),  row(srs_pkg::OpAdd, 64'd20),
      row(srs_pkg::OpAdd, 64'd30),  row(srs_pkg::OpAdd, 64'd40),
      row(srs_pkg::OpAdd, 64'd50),  row(srs_pkg::OpAdd, 64'd60),
      row(srs_pkg::OpAdd, 64'd70),  row(srs_pkg::OpAdd, 64'd80),
      row(srs_pkg::OpAdd, 64'd90),  row(srs_pkg::OpAdd, 64'd100),
      row(srs_pkg::OpAdd, 64'd110), row(srs_pkg::OpAdd, 64'd120),
      row(srs_pkg::OpAdd, 64'd130), row(srs_pkg::OpAdd, 64'd140),
      row(srs_pkg::OpAdd,   64'd200,       1'b1, 1'b0, 1'b1, 5'd16),
      row(srs_pkg::OpAdd,   64'd11,        1'b1, 1'b0, 1'b0, 5'd16),
      row(srs_pkg::OpQuery, 64'd150,       1'b1, 1'b0, 1'b0, 5'd16)
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    sender_idle_pct = 12;
    foreach (dir_tbl[i]) send_req(dir_tbl[i].req, dir_tbl[i].expect_set, dir_tbl[i].rsp);
    drain_results();

    // Three random phases: light sender gaps, heavy gaps, then
    // back-to-back. All results are drained between phases.
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 69 : 0;
      repeat (RandPerPhase) send_req(next_random_req());
      drain_results();
    end

    waited = 0;
    while (pending_rsp.size() != 0 && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
